### rtl/bba_pkg.sv
// shared constants and codes for the bitmap block allocator
package bba_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_WORD_BITS  = 64;

  localparam int CNT_W     = 11;
  localparam int SIZE_W    = 16;
  localparam int IDX_W     = 10;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int S_DATA_W  = 32;
  localparam int M_DATA_W  = 24;

  localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = 11'd1024;
  localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 16'd64;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 3'd4;

endpackage

### rtl/bba_map_ram.sv
// used-bit map memory, one write port and one registered read port
module bba_map_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bba_scan_unit.sv
// find-first-free unit over one map word, limited to the active block count
module bba_scan_unit import bba_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int MAP_AW    = 4
) (
  input  logic [WORD_BITS-1:0]         word_i,
  input  logic [MAP_AW-1:0]            word_idx_i,
  input  logic [CNT_W-1:0]             count_i,
  output logic                         found_o,
  output logic [$clog2(WORD_BITS)-1:0] pos_o
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [CNT_W-1:0]     base;
  logic [CNT_W-1:0]     remain;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     pos;

  assign base   = CNT_W'(word_idx_i) << BIT_W;
  assign remain = count_i - base;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (CNT_W'(b) < remain);
    end
  end

  assign free_bits = ~word_i & mask;
  // isolate the lowest set bit
  assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

  always_comb begin
    pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        pos = pos | BIT_W'(b);
      end
    end
  end

  assign found_o = |free_bits;
  assign pos_o   = pos;

endmodule

### rtl/bitmap_block_allocator_unit.sv
// Fixed-size block allocator: one used bit per block, kept in a map memory of WORD_BITS-bit
// words, searched lowest index first by a single find-first-free unit that looks at one word
// per cycle. An allocate reads map words upward from word 0 until a free block is found, at
// most ceil(block_count / WORD_BITS) words, 16 with the defaults, at the pace of the map
// memory's single read port. A free reads the word that holds its block and clears the bit if
// set; a request rejected on size, range or an empty pool goes straight to its result. The
// input is ready only when no request is in progress; a result waits in the output register
// without holding up the next request's search. After reset and after every write of
// block_count the map is cleared over all ceil(min(MAX_BLOCKS, 2047) / WORD_BITS) words, one
// word per cycle, during which no request is taken. WORD_BITS must be a power of two.
module bitmap_block_allocator_unit import bba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = DEF_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // request_bytes[15:0], free_index[25:16], zero fill
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[2:0], granted_index[12:3], blocks_free[23:13]
  output logic [M_DATA_W-1:0]  m_axis_tdata
);

  localparam int CAP_LIMIT  = (1 << CNT_W) - 1;
  localparam int CAP_BLOCKS = (MAX_BLOCKS < CAP_LIMIT) ? MAX_BLOCKS : CAP_LIMIT;
  localparam int MAP_WORDS  = (CAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP_BLOCKS);
  localparam logic [CNT_W-1:0] RST_EFF =
    (RST_BLOCK_COUNT > CAP_CNT) ? CAP_CNT : RST_BLOCK_COUNT;
  localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(MAP_WORDS - 1);

  localparam int SW = 3;
  localparam logic [SW-1:0] S_IDLE  = 3'd0;
  localparam logic [SW-1:0] S_CLEAR = 3'd1;
  localparam logic [SW-1:0] S_SCAN  = 3'd2;
  localparam logic [SW-1:0] S_FREE  = 3'd3;
  localparam logic [SW-1:0] S_DONE  = 3'd4;

  logic [SW-1:0]     state_q, state_d;
  logic [MAP_AW-1:0] clr_addr_q, clr_addr_d;
  logic [CNT_W-1:0]  eff_count_q, eff_count_d;
  logic [SIZE_W-1:0] block_size_q, block_size_d;
  logic [CNT_W-1:0]  free_blocks_q, free_blocks_d;
  logic              m_valid_q, m_valid_d;

  logic [MAP_AW-1:0] scan_w_q, scan_w_d;
  logic [IDX_W-1:0]  fidx_q, fidx_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]  res_grant_q, res_grant_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [IDX_W-1:0]  out_grant_q, out_grant_d;
  logic [CNT_W-1:0]  out_free_q, out_free_d;

  logic                 ram_we;
  logic [MAP_AW-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [MAP_AW-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic             scan_found;
  logic [BIT_W-1:0] scan_pos;
  logic [CNT_W-1:0] grant_idx;
  logic [MAP_AW-1:0] last_word;

  logic              s_fire;
  logic [SIZE_W-1:0] in_req;
  logic [IDX_W-1:0]  in_fidx;
  logic [CNT_W-1:0]  cfg_eff;
  logic [BIT_W-1:0]  fidx_bit;

  bba_map_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS),
    .AW   (MAP_AW)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bba_scan_unit #(
    .WORD_BITS(WORD_BITS),
    .MAP_AW   (MAP_AW)
  ) u_scan_unit (
    .word_i    (ram_rdata),
    .word_idx_i(scan_w_q),
    .count_i   (eff_count_q),
    .found_o   (scan_found),
    .pos_o     (scan_pos)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_req        = s_axis_tdata[SIZE_W-1:0];
  assign in_fidx       = s_axis_tdata[SIZE_W+IDX_W-1:SIZE_W];
  assign grant_idx     = (CNT_W'(scan_w_q) << BIT_W) | CNT_W'(scan_pos);
  assign last_word     = MAP_AW'((eff_count_q - CNT_W'(1)) >> BIT_W);
  assign fidx_bit      = fidx_q[BIT_W-1:0];
  assign cfg_eff       = (cfg_wdata_i[CNT_W-1:0] > CAP_CNT) ? CAP_CNT : cfg_wdata_i[CNT_W-1:0];

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    eff_count_d   = eff_count_q;
    block_size_d  = block_size_q;
    free_blocks_d = free_blocks_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    scan_w_d      = scan_w_q;
    fidx_d        = fidx_q;
    res_status_d  = res_status_q;
    res_grant_d   = res_grant_q;
    out_status_d  = out_status_q;
    out_grant_d   = out_grant_q;
    out_free_d    = out_free_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        if (clr_addr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + MAP_AW'(1);
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          fidx_d      = in_fidx;
          res_grant_d = '0;
          if (s_axis_tuser[0] == CMD_ALLOC) begin
            if (in_req > block_size_q) begin
              res_status_d = STAT_TOO_LARGE;
              state_d      = S_DONE;
            end else if (eff_count_q == '0) begin
              res_status_d = STAT_FULL;
              state_d      = S_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              scan_w_d  = '0;
              state_d   = S_SCAN;
            end
          end else begin
            if ({1'b0, in_fidx} >= eff_count_q) begin
              res_status_d = STAT_RANGE;
              state_d      = S_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = MAP_AW'({1'b0, in_fidx} >> BIT_W);
              state_d   = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          ram_we       = 1'b1;
          ram_waddr    = scan_w_q;
          ram_wdata    = ram_rdata | (WORD_BITS'(1) << scan_pos);
          res_status_d = STAT_OK;
          res_grant_d  = grant_idx[IDX_W-1:0];
          if (free_blocks_q != '0) begin
            free_blocks_d = free_blocks_q - CNT_W'(1);
          end
          state_d = S_DONE;
        end else if (scan_w_q == last_word) begin
          res_status_d = STAT_FULL;
          state_d      = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_w_q + MAP_AW'(1);
          scan_w_d  = scan_w_q + MAP_AW'(1);
        end
      end
      S_FREE: begin
        if (!ram_rdata[fidx_bit]) begin
          res_status_d = STAT_NOT_ALLOC;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = MAP_AW'({1'b0, fidx_q} >> BIT_W);
          ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << fidx_bit);
          res_status_d = STAT_OK;
          if (free_blocks_q < eff_count_q) begin
            free_blocks_d = free_blocks_q + CNT_W'(1);
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_status_d = res_status_q;
          out_grant_d  = res_grant_q;
          out_free_d   = free_blocks_q;
          m_valid_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_COUNT: begin
          eff_count_d   = cfg_eff;
          free_blocks_d = cfg_eff;
          clr_addr_d    = '0;
          state_d       = S_CLEAR;
        end
        REG_BLOCK_SIZE: begin
          block_size_d = cfg_wdata_i[SIZE_W-1:0];
        end
        default: begin
          block_size_d = block_size_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_addr_q    <= '0;
      eff_count_q   <= RST_EFF;
      block_size_q  <= RST_BLOCK_SIZE;
      free_blocks_q <= RST_EFF;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      eff_count_q   <= eff_count_d;
      block_size_q  <= block_size_d;
      free_blocks_q <= free_blocks_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_w_q     <= scan_w_d;
    fidx_q       <= fidx_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
    out_free_q   <= out_free_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_free_q, out_grant_q, out_status_q};

`ifndef SYNTHESIS
  a_free_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_blocks_q <= eff_count_q)
    else $error("free block count above active block count");

  a_grant_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && scan_found |-> grant_idx < eff_count_q)
    else $error("granted block outside the active pool");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> scan_w_q <= last_word)
    else $error("scan past the last active map word");

  a_count_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_BLOCK_COUNT) |=> state_q == S_CLEAR)
    else $error("block count write did not start a map clear");
`endif

endmodule

### dv/bitmap_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// testbench for the bitmap block allocator: directed and random alloc/free traffic, checked in order
module bitmap_block_allocator_unit_tb;
  import bba_pkg::*;

  localparam int MAP_WORDS   = DEF_MAX_BLOCKS / DEF_WORD_BITS;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] bytes;
    logic [IDX_W-1:0]  index;
  } request_t;

  // same bit order as m_axis_tdata
  typedef struct packed {
    logic [CNT_W-1:0]  blocks_free;
    logic [IDX_W-1:0]  granted;
    logic [STAT_W-1:0] status;
  } grant_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_DATA_W-1:0]  m_axis_tdata;

  // shadow of the pool
  logic [DEF_WORD_BITS-1:0] used_words [MAP_WORDS];
  logic [CNT_W-1:0]         pool_count;
  logic [SIZE_W-1:0]        pool_bsize;
  logic [CNT_W-1:0]         pool_free;

  request_t    pending_reqs [$];
  grant_t      awaited_grants [$];
  request_t    s_item;
  logic        s_taken     = 1'b0;
  logic        drain_hold  = 1'b0;
  int          s_idle_pct  = 34;
  int          m_idle_pct  = 34;
  int          err_cnt     = 0;
  int          idle_cycles = 0;
  int unsigned issued      = 0;

  bitmap_block_allocator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pool_limit();
    return (pool_count > CNT_W'(DEF_MAX_BLOCKS)) ? DEF_MAX_BLOCKS : int'(pool_count);
  endfunction

  function automatic void clear_pool();
    for (int w = 0; w < MAP_WORDS; w++) used_words[w] = '0;
    pool_free = CNT_W'(pool_limit());
  endfunction

  function automatic grant_t serve_request(input request_t r);
    grant_t      res;
    int unsigned lim;
    logic        found;
    res   = '0;
    lim   = pool_limit();
    found = 1'b0;
    if (r.cmd == CMD_ALLOC) begin
      if (r.bytes > pool_bsize) begin
        res.status = STAT_TOO_LARGE;
      end else begin
        for (int unsigned n = 0; n < lim; n++) begin
          if (!found && !used_words[n / DEF_WORD_BITS][n % DEF_WORD_BITS]) begin
            used_words[n / DEF_WORD_BITS][n % DEF_WORD_BITS] = 1'b1;
            res.granted = IDX_W'(n);
            found       = 1'b1;
          end
        end
        if (found) begin
          if (pool_free != 0) pool_free = pool_free - 1'b1;
        end else begin
          res.status = STAT_FULL;
        end
      end
    end else if (int'(r.index) >= lim) begin
      res.status = STAT_RANGE;
    end else if (!used_words[r.index / DEF_WORD_BITS][r.index % DEF_WORD_BITS]) begin
      res.status = STAT_NOT_ALLOC;
    end else begin
      used_words[r.index / DEF_WORD_BITS][r.index % DEF_WORD_BITS] = 1'b0;
      if (pool_free < CNT_W'(lim)) pool_free = pool_free + 1'b1;
    end
    res.blocks_free = pool_free;
    return res;
  endfunction

  // driver
  always @(negedge clk_i) begin
    request_t nxt;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= m_idle_pct);
      if (drain_hold && awaited_grants.size() == 0) drain_hold = 1'b0;
      if (!s_axis_tvalid || s_taken) begin
        s_taken = 1'b0;
        if (pending_reqs.size() != 0 && !drain_hold && $urandom_range(99) >= s_idle_pct) begin
          nxt = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_DATA_W'({nxt.index, nxt.bytes});
          s_axis_tuser  <= nxt.cmd;
          s_item        <= nxt;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    grant_t want;
    grant_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = grant_t'(m_axis_tdata);
        if (awaited_grants.size() == 0) begin
          $error("result transfer with no request outstanding");
          err_cnt++;
        end else begin
          want = awaited_grants.pop_front();
          if (got.status != want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            err_cnt++;
          end
          if (got.granted != want.granted) begin
            $error("granted_index expected %0d got %0d", want.granted, got.granted);
            err_cnt++;
          end
          if (got.blocks_free != want.blocks_free) begin
            $error("blocks_free expected %0d got %0d", want.blocks_free, got.blocks_free);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_grants.push_back(serve_request(s_item));
        s_taken = 1'b1;
        if ($urandom_range(99) == 0) drain_hold = 1'b1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("bitmap_block_allocator_unit_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // checked at the rising edge, where the driver never changes the queue or tvalid
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || awaited_grants.size() != 0 ||
           !s_axis_tready)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BLOCK_COUNT) begin
      pool_count = CNT_W'(value);
      clear_pool();
    end else begin
      pool_bsize = SIZE_W'(value);
    end
  endtask

  // a negative count leaves the block count and its map alone; the block size is still written
  task automatic set_pool(input int count, input int bsize);
    wait_idle();
    write_reg(REG_BLOCK_SIZE, bsize);
    if (count >= 0) begin
      write_reg(REG_BLOCK_COUNT, count);
      issued = 0;
    end
    @(posedge clk_i);
  endtask

  task automatic queue_req(input logic cmd, input int bytes, input int index);
    request_t r;
    r.cmd   = cmd;
    r.bytes = SIZE_W'(bytes);
    r.index = IDX_W'(index);
    pending_reqs.push_back(r);
  endtask

  task automatic run_phase(input int count, input int bsize, input int n_items,
                           input int alloc_pct, input int idle_pct);
    request_t    r;
    int unsigned lim;
    int unsigned hi;
    int          pick;
    set_pool(count, bsize);
    s_idle_pct = idle_pct;
    m_idle_pct = idle_pct;
    lim = pool_limit();
    repeat (n_items) begin
      r.cmd = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
      pick  = $urandom_range(9);
      if (pick < 7) r.bytes = SIZE_W'($urandom_range(bsize));
      else if (pick < 9 && bsize < 65535) r.bytes = SIZE_W'($urandom_range(65535, bsize + 1));
      else r.bytes = SIZE_W'($urandom());
      // frees mostly aim at blocks that are likely in use
      hi = (issued < lim) ? issued : lim;
      if (hi == 0 || $urandom_range(9) == 0) r.index = IDX_W'($urandom());
      else r.index = IDX_W'($urandom_range(hi - 1));
      if (r.cmd == CMD_ALLOC) issued++;
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_BLOCK_COUNT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ALLOC;
    m_axis_tready = 1'b0;
    pool_count    = RST_BLOCK_COUNT;
    pool_bsize    = RST_BLOCK_SIZE;
    clear_pool();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    queue_req(CMD_ALLOC, 0, 0);
    queue_req(CMD_ALLOC, 64, 0);
    queue_req(CMD_ALLOC, 65, 0);
    queue_req(CMD_ALLOC, 65535, 0);
    queue_req(CMD_FREE, 0, 1);
    queue_req(CMD_FREE, 0, 1);
    queue_req(CMD_FREE, 0, 1023);
    queue_req(CMD_ALLOC, 1, 0);

    // tiny pool run to full, size check ahead of full, out of range frees
    set_pool(3, 16);
    queue_req(CMD_ALLOC, 16, 0);
    queue_req(CMD_ALLOC, 0, 0);
    queue_req(CMD_ALLOC, 5, 0);
    queue_req(CMD_ALLOC, 3, 0);
    queue_req(CMD_ALLOC, 17, 0);
    queue_req(CMD_FREE, 0, 3);
    queue_req(CMD_FREE, 0, 1023);
    queue_req(CMD_FREE, 0, 2);
    queue_req(CMD_ALLOC, 16, 0);

    // empty pool and zero block size
    set_pool(0, 0);
    queue_req(CMD_ALLOC, 0, 0);
    queue_req(CMD_ALLOC, 1, 0);
    queue_req(CMD_FREE, 0, 0);

    // count above the pool maximum saturates
    set_pool(2047, 65535);
    queue_req(CMD_ALLOC, 65535, 0);
    queue_req(CMD_FREE, 0, 0);

    run_phase(1024, 64, 250, 70, 34);
    run_phase(70, 1000, 200, 55, 34);
    run_phase(5, 16, 150, 50, 34);
    run_phase(-1, 1, 100, 50, 34);
    run_phase(300, 65535, 350, 85, 0);
    run_phase(2047, 200, 200, 60, 34);
    run_phase(1, 1, 60, 50, 34);
    run_phase(64, 512, 150, 55, 34);
    run_phase(0, 300, 20, 50, 34);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && awaited_grants.size() == 0) begin
      $display("bitmap_block_allocator_unit_tb: PASS");
    end else begin
      $display("bitmap_block_allocator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_scan_unit.sv
rtl/bitmap_block_allocator_unit.sv
dv/bitmap_block_allocator_unit_tb.sv
